// ----- rtl/rsd_pkg.sv -----
package rsd_pkg;

    typedef logic signed [15:0] coord_t;
    typedef logic signed [16:0] diff_t;
    typedef logic signed [33:0] prod_t;
    typedef logic signed [34:0] cross_t;

    localparam int S_TDATA_W = 112;
    localparam int M_TDATA_W = 24;
    localparam int DIST_W    = 17;
    localparam logic [DIST_W-1:0] DIST_MAX = '1;

    localparam logic ACT_LOAD = 1'b0;
    localparam logic ACT_CAST = 1'b1;

    typedef struct packed {
        logic        start;
        logic [34:0] num;
        logic [34:0] den;
        diff_t       d1x;
        diff_t       d1y;
    } dist_req_t;

    typedef struct packed {
        logic              done;
        logic [DIST_W-1:0] distance;
    } dist_rsp_t;

endpackage

// ----- rtl/rsd_dist.sv -----
module rsd_dist (
    input  logic               aclk,
    input  logic               aresetn,
    input  rsd_pkg::dist_req_t req,
    output rsd_pkg::dist_rsp_t rsp
);
    import rsd_pkg::*;

    localparam logic [2:0] D_IDLE = 3'd0;
    localparam logic [2:0] D_DIV  = 3'd1;
    localparam logic [2:0] D_SQX  = 3'd2;
    localparam logic [2:0] D_SQY  = 3'd3;
    localparam logic [2:0] D_SUM  = 3'd4;
    localparam logic [2:0] D_SQRT = 3'd5;
    localparam logic [2:0] D_MUL  = 3'd6;
    localparam logic [2:0] D_RND  = 3'd7;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  cnt_reg, cnt_next;
    logic [34:0] rem_reg, rem_next;
    logic [34:0] den_reg, den_next;
    logic [31:0] q_reg, q_next;
    logic [16:0] ax_reg, ax_next;
    logic [16:0] ay_reg, ay_next;
    logic [56:0] prod_reg, prod_next;
    logic [49:0] rad_reg, rad_next;
    logic [26:0] srem_reg, srem_next;
    logic [24:0] root_reg, root_next;
    logic        done_reg, done_next;
    logic [DIST_W-1:0] dist_reg, dist_next;

    logic [35:0] div_sh;
    logic [28:0] sq_sh;
    logic [28:0] sq_trial;
    logic [31:0] mul_a;
    logic [24:0] mul_b;
    logic [57:0] rnd_sum;

    assign div_sh   = {rem_reg, 1'b0};
    assign sq_sh    = {srem_reg, rad_reg[49:48]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign rnd_sum  = {1'b0, prod_reg} + (58'd1 << 39);

    always_comb begin
        case (state_reg)
            D_SQX: begin
                mul_a = {15'd0, ax_reg};
                mul_b = {8'd0, ax_reg};
            end
            D_SQY: begin
                mul_a = {15'd0, ay_reg};
                mul_b = {8'd0, ay_reg};
            end
            default: begin
                mul_a = q_reg;
                mul_b = root_reg;
            end
        endcase
    end

    always_comb begin
        state_next = state_reg;
        cnt_next   = cnt_reg;
        rem_next   = rem_reg;
        den_next   = den_reg;
        q_next     = q_reg;
        ax_next    = ax_reg;
        ay_next    = ay_reg;
        prod_next  = prod_reg;
        rad_next   = rad_reg;
        srem_next  = srem_reg;
        root_next  = root_reg;
        done_next  = 1'b0;
        dist_next  = dist_reg;
        case (state_reg)
            D_IDLE: begin
                if (req.start) begin
                    rem_next   = req.num;
                    den_next   = req.den;
                    q_next     = '0;
                    cnt_next   = 5'd31;
                    ax_next    = req.d1x[16] ? 17'(-req.d1x) : 17'(req.d1x);
                    ay_next    = req.d1y[16] ? 17'(-req.d1y) : 17'(req.d1y);
                    state_next = D_DIV;
                end
            end
            D_DIV: begin
                // one quotient bit per cycle, remainder stays below den
                if (div_sh >= {1'b0, den_reg}) begin
                    rem_next = 35'(div_sh - {1'b0, den_reg});
                    q_next   = {q_reg[30:0], 1'b1};
                end else begin
                    rem_next = div_sh[34:0];
                    q_next   = {q_reg[30:0], 1'b0};
                end
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = D_SQX;
                end
            end
            D_SQX: begin
                prod_next  = 57'(mul_a * mul_b);
                state_next = D_SQY;
            end
            D_SQY: begin
                rad_next   = {1'b0, prod_reg[32:0], 16'd0};
                prod_next  = 57'(mul_a * mul_b);
                state_next = D_SUM;
            end
            D_SUM: begin
                rad_next   = rad_reg + {1'b0, prod_reg[32:0], 16'd0};
                srem_next  = '0;
                root_next  = '0;
                cnt_next   = 5'd24;
                state_next = D_SQRT;
            end
            D_SQRT: begin
                // one root bit per cycle from the top two radicand bits
                if (sq_sh >= sq_trial) begin
                    srem_next = 27'(sq_sh - sq_trial);
                    root_next = {root_reg[23:0], 1'b1};
                end else begin
                    srem_next = sq_sh[26:0];
                    root_next = {root_reg[23:0], 1'b0};
                end
                rad_next = {rad_reg[47:0], 2'b00};
                cnt_next = cnt_reg - 5'd1;
                if (cnt_reg == 5'd0) begin
                    state_next = D_MUL;
                end
            end
            D_MUL: begin
                prod_next  = 57'(mul_a * mul_b);
                state_next = D_RND;
            end
            D_RND: begin
                dist_next  = (rnd_sum[57:40] > {1'b0, DIST_MAX}) ? DIST_MAX
                                                                 : rnd_sum[56:40];
                done_next  = 1'b1;
                state_next = D_IDLE;
            end
            default: state_next = D_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= D_IDLE;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            done_reg  <= done_next;
        end
        cnt_reg  <= cnt_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        q_reg    <= q_next;
        ax_reg   <= ax_next;
        ay_reg   <= ay_next;
        prod_reg <= prod_next;
        rad_reg  <= rad_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
        dist_reg <= dist_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.distance = dist_reg;

    a_start_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (req.start && state_reg == D_IDLE) |=> state_reg == D_DIV)
        else $error("divider did not start");
    a_done_pulse: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> $past(state_reg) == D_RND)
        else $error("done without rounding step");
    a_idle_done: assert property (@(posedge aclk) disable iff (!aresetn)
        done_reg |-> state_reg == D_IDLE)
        else $error("done while busy");

endmodule

// ----- rtl/ray_segment_sensor_distance.sv -----
// channel | direction | handshake             | payload
// s_      | in        | s_tvalid / s_tready   | s_tuser action, s_tdata load or cast fields
// m_      | out       | m_tvalid / m_tready   | m_tdata sensor_echo, hit, distance
// cfg_    | in        | cfg_valid / cfg_ready | cfg_data vertex_count
// A load does not hold s_tready low. A cast holds s_tready low while it runs, set by the
// shared 17x17 multiplier (6 products per segment) and, when a segment is hit, by the
// bit-serial divider and square root at the end.
// Reset is synchronous on aresetn; the vertex store is not cleared.
// s_tready is low while a cast runs; a waiting result in the output register
// does not block the next item until the following result is ready.
module ray_segment_sensor_distance #(
    parameter int MAX_VERTICES = 64
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_tvalid,
    output logic                          s_tready,
    // [5:0] vertex_index, [21:6] vertex_x, [37:22] vertex_y, [40:38] sensor_index,
    // [56:41] ray_start_x, [72:57] ray_start_y, [88:73] ray_end_x, [104:89] ray_end_y
    input  logic [rsd_pkg::S_TDATA_W-1:0] s_tdata,
    // [0] action
    input  logic                          s_tuser,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    // [2:0] sensor_echo, [3] hit, [20:4] distance
    output logic [rsd_pkg::M_TDATA_W-1:0] m_tdata,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic [6:0]                    cfg_data
);
    import rsd_pkg::*;

    localparam int AW = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int CW = $clog2(MAX_VERTICES + 1);

    localparam logic [3:0] S_IDLE   = 4'd0;
    localparam logic [3:0] S_FETCH0 = 4'd1;
    localparam logic [3:0] S_LATCH0 = 4'd2;
    localparam logic [3:0] S_FETCH  = 4'd3;
    localparam logic [3:0] S_SEG    = 4'd4;
    localparam logic [3:0] S_MUL    = 4'd5;
    localparam logic [3:0] S_CHECK  = 4'd6;
    localparam logic [3:0] S_DIST   = 4'd7;
    localparam logic [3:0] S_OUT    = 4'd8;

    coord_t mem_x [MAX_VERTICES];
    coord_t mem_y [MAX_VERTICES];
    coord_t rd_x_reg, rd_y_reg;

    logic [6:0]    count_reg;
    logic [3:0]    state_reg, state_next;
    logic [CW-1:0] n_reg, n_next;
    logic [CW-1:0] j_reg, j_next;
    logic [2:0]    mk_reg, mk_next;
    logic [2:0]    sensor_reg, sensor_next;
    coord_t        x1_reg, x1_next, y1_reg, y1_next;
    diff_t         d1x_reg, d1x_next, d1y_reg, d1y_next;
    coord_t        px_reg, px_next, py_reg, py_next;
    diff_t         d2x_reg, d2x_next, d2y_reg, d2y_next;
    diff_t         wx_reg, wx_next, wy_reg, wy_next;
    prod_t         prod_reg, prod_next;
    prod_t         acc_reg, acc_next;
    cross_t        den_reg, den_next, na_reg, na_next, nb_reg, nb_next;
    logic          hit_reg, hit_next;
    logic [34:0]   hna_reg, hna_next, hden_reg, hden_next;
    logic          m_tvalid_reg, m_tvalid_next;
    logic [M_TDATA_W-1:0] m_tdata_reg, m_tdata_next;

    logic          s_fire;
    logic [AW-1:0] rd_addr;
    logic [AW-1:0] wr_addr;
    logic          wr_en;
    logic [CW-1:0] n_cast;
    diff_t         mul_a, mul_b;
    cross_t        diff_val;
    cross_t        cden, cna, cnb;
    logic          seg_hit;
    logic          more_seg;
    logic          out_free;
    dist_req_t     dreq;
    dist_rsp_t     drsp;

    assign cfg_ready = 1'b1;
    assign s_tready  = (state_reg == S_IDLE);
    assign s_fire    = s_tvalid && s_tready;
    assign out_free  = !m_tvalid_reg || m_tready;

    assign wr_addr = AW'(s_tdata[5:0]);
    assign wr_en   = s_fire && (s_tuser == ACT_LOAD)
                     && (32'(s_tdata[5:0]) < 32'(MAX_VERTICES));
    assign rd_addr = (state_reg == S_FETCH0) ? '0 : AW'(j_reg + CW'(1));
    assign n_cast  = (32'(count_reg) > 32'(MAX_VERTICES)) ? CW'(MAX_VERTICES)
                                                          : CW'(count_reg);
    assign more_seg = (32'(j_reg) + 32'd2) < 32'(n_reg);

    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mem_x[wr_addr] <= coord_t'(s_tdata[21:6]);
            mem_y[wr_addr] <= coord_t'(s_tdata[37:22]);
        end
        rd_x_reg <= mem_x[rd_addr];
        rd_y_reg <= mem_y[rd_addr];
    end

    always_comb begin
        case (mk_reg)
            3'd0:    begin mul_a = d2y_reg; mul_b = d1x_reg; end
            3'd1:    begin mul_a = d2x_reg; mul_b = d1y_reg; end
            3'd2:    begin mul_a = d2x_reg; mul_b = wy_reg;  end
            3'd3:    begin mul_a = d2y_reg; mul_b = wx_reg;  end
            3'd4:    begin mul_a = d1x_reg; mul_b = wy_reg;  end
            default: begin mul_a = d1y_reg; mul_b = wx_reg;  end
        endcase
    end

    assign diff_val = cross_t'(acc_reg) - cross_t'(prod_reg);

    // flip signs so the denominator is not negative
    assign cden = den_reg[34] ? -den_reg : den_reg;
    assign cna  = den_reg[34] ? -na_reg  : na_reg;
    assign cnb  = den_reg[34] ? -nb_reg  : nb_reg;
    assign seg_hit = (cden > 0) && (cna > 0) && (cna < cden) && (cnb > 0) && (cnb < cden);

    always_comb begin
        state_next    = state_reg;
        n_next        = n_reg;
        j_next        = j_reg;
        mk_next       = mk_reg;
        sensor_next   = sensor_reg;
        x1_next       = x1_reg;
        y1_next       = y1_reg;
        d1x_next      = d1x_reg;
        d1y_next      = d1y_reg;
        px_next       = px_reg;
        py_next       = py_reg;
        d2x_next      = d2x_reg;
        d2y_next      = d2y_reg;
        wx_next       = wx_reg;
        wy_next       = wy_reg;
        prod_next     = prod_reg;
        acc_next      = acc_reg;
        den_next      = den_reg;
        na_next       = na_reg;
        nb_next       = nb_reg;
        hit_next      = hit_reg;
        hna_next      = hna_reg;
        hden_next     = hden_reg;
        m_tvalid_next = m_tvalid_reg && !m_tready;
        m_tdata_next  = m_tdata_reg;
        dreq.start    = 1'b0;
        dreq.num      = hna_reg;
        dreq.den      = hden_reg;
        dreq.d1x      = d1x_reg;
        dreq.d1y      = d1y_reg;
        case (state_reg)
            S_IDLE: begin
                if (s_fire && s_tuser == ACT_CAST) begin
                    sensor_next = s_tdata[40:38];
                    x1_next     = coord_t'(s_tdata[56:41]);
                    y1_next     = coord_t'(s_tdata[72:57]);
                    d1x_next    = diff_t'(coord_t'(s_tdata[88:73]))
                                  - diff_t'(coord_t'(s_tdata[56:41]));
                    d1y_next    = diff_t'(coord_t'(s_tdata[104:89]))
                                  - diff_t'(coord_t'(s_tdata[72:57]));
                    n_next      = n_cast;
                    j_next      = '0;
                    hit_next    = 1'b0;
                    state_next  = (32'(n_cast) < 32'd2) ? S_OUT : S_FETCH0;
                end
            end
            S_FETCH0: state_next = S_LATCH0;
            S_LATCH0: begin
                px_next    = rd_x_reg;
                py_next    = rd_y_reg;
                state_next = S_FETCH;
            end
            S_FETCH: state_next = S_SEG;
            S_SEG: begin
                d2x_next   = diff_t'(rd_x_reg) - diff_t'(px_reg);
                d2y_next   = diff_t'(rd_y_reg) - diff_t'(py_reg);
                wx_next    = diff_t'(x1_reg) - diff_t'(px_reg);
                wy_next    = diff_t'(y1_reg) - diff_t'(py_reg);
                px_next    = rd_x_reg;
                py_next    = rd_y_reg;
                mk_next    = '0;
                state_next = S_MUL;
            end
            S_MUL: begin
                // product k is registered, then folded in the next cycle
                if (mk_reg != 3'd6) begin
                    prod_next = mul_a * mul_b;
                end
                if (mk_reg != 3'd0) begin
                    case (mk_reg)
                        3'd2:    den_next = diff_val;
                        3'd4:    na_next  = diff_val;
                        3'd6:    nb_next  = diff_val;
                        default: acc_next = prod_reg;
                    endcase
                end
                mk_next = mk_reg + 3'd1;
                if (mk_reg == 3'd6) begin
                    state_next = S_CHECK;
                end
            end
            S_CHECK: begin
                if (seg_hit) begin
                    hit_next  = 1'b1;
                    hna_next  = 35'(cna);
                    hden_next = 35'(cden);
                end
                if (more_seg) begin
                    j_next     = j_reg + CW'(1);
                    state_next = S_FETCH;
                end else if (seg_hit || hit_reg) begin
                    dreq.start = 1'b1;
                    dreq.num   = seg_hit ? 35'(cna) : hna_reg;
                    dreq.den   = seg_hit ? 35'(cden) : hden_reg;
                    state_next = S_DIST;
                end else begin
                    state_next = S_OUT;
                end
            end
            S_DIST: begin
                if (drsp.done) begin
                    state_next = S_OUT;
                end
            end
            S_OUT: begin
                // hold until the previous result has been taken
                if (out_free) begin
                    m_tvalid_next = 1'b1;
                    m_tdata_next  = {3'd0, hit_reg ? drsp.distance : DIST_W'(0),
                                     hit_reg, sensor_reg};
                    state_next    = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    rsd_dist u_dist (
        .aclk    (aclk),
        .aresetn (aresetn),
        .req     (dreq),
        .rsp     (drsp)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= S_IDLE;
            count_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            m_tvalid_reg <= m_tvalid_next;
            if (cfg_valid && cfg_ready) begin
                count_reg <= cfg_data;
            end
        end
        n_reg       <= n_next;
        j_reg       <= j_next;
        mk_reg      <= mk_next;
        sensor_reg  <= sensor_next;
        x1_reg      <= x1_next;
        y1_reg      <= y1_next;
        d1x_reg     <= d1x_next;
        d1y_reg     <= d1y_next;
        px_reg      <= px_next;
        py_reg      <= py_next;
        d2x_reg     <= d2x_next;
        d2y_reg     <= d2y_next;
        wx_reg      <= wx_next;
        wy_reg      <= wy_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        den_reg     <= den_next;
        na_reg      <= na_next;
        nb_reg      <= nb_next;
        hit_reg     <= hit_next;
        hna_reg     <= hna_next;
        hden_reg    <= hden_next;
        m_tdata_reg <= m_tdata_next;
    end

    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = m_tdata_reg;

    a_no_hit_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_tvalid && !m_tdata[3]) |-> m_tdata[20:4] == '0)
        else $error("distance set without hit");
    a_cast_busy: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == ACT_CAST) |=> !s_tready)
        else $error("ready during cast");
    a_load_silent: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_tuser == ACT_LOAD && !m_tvalid) |=> !m_tvalid)
        else $error("load produced a result");

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 100ps

module testbench;
    import rsd_pkg::*;

    typedef struct {
        logic [2:0]        sensor;
        logic              hit;
        logic [DIST_W-1:0] distance;
    } echo_t;

    class ray_scoreboard;
        logic [15:0] map_x [64];
        logic [15:0] map_y [64];
        logic [6:0]  vertex_count;
        echo_t       pending_echoes [$];
        int          errors;

        function new();
            vertex_count = 0;
            errors = 0;
        endfunction

        function longint unsigned root_floor(longint unsigned v);
            longint unsigned res;
            longint unsigned bitv;
            res = 0;
            bitv = 64'd1 << 62;
            while (bitv > v) bitv >>= 2;
            while (bitv != 0) begin
                if (v >= res + bitv) begin
                    v -= res + bitv;
                    res = (res >> 1) + bitv;
                end else begin
                    res >>= 1;
                end
                bitv >>= 2;
            end
            return res;
        endfunction

        // Update the map on a load, or predict the echo of a cast.
        function void note_item(logic act, logic [S_TDATA_W-1:0] d);
            longint x1, y1, x2, y2, d1x, d1y, x3, y3, x4, y4;
            longint d2x, d2y, wx, wy, den, na, nb;
            longint unsigned len8, total;
            logic [95:0] quot;
            logic [31:0] frac;
            int n;
            echo_t e;
            if (act == ACT_LOAD) begin
                map_x[d[5:0]] = d[21:6];
                map_y[d[5:0]] = d[37:22];
                return;
            end
            x1 = $signed(d[56:41]);
            y1 = $signed(d[72:57]);
            x2 = $signed(d[88:73]);
            y2 = $signed(d[104:89]);
            d1x = x2 - x1;
            d1y = y2 - y1;
            n = (vertex_count > 64) ? 64 : vertex_count;
            e.sensor = d[40:38];
            e.hit = 0;
            e.distance = 0;
            frac = 0;
            for (int j = 0; j + 1 < n; j++) begin
                x3 = $signed(map_x[j]);
                y3 = $signed(map_y[j]);
                x4 = $signed(map_x[j+1]);
                y4 = $signed(map_y[j+1]);
                d2x = x4 - x3;
                d2y = y4 - y3;
                wx = x1 - x3;
                wy = y1 - y3;
                den = d2y * d1x - d2x * d1y;
                na = d2x * wy - d2y * wx;
                nb = d1x * wy - d1y * wx;
                if (den < 0) begin
                    den = -den;
                    na = -na;
                    nb = -nb;
                end
                if (den > 0 && na > 0 && na < den && nb > 0 && nb < den) begin
                    quot = {64'(na), 32'd0} / 96'(den);
                    frac = quot[31:0];
                    e.hit = 1;
                end
            end
            if (e.hit) begin
                len8 = root_floor(64'(d1x * d1x + d1y * d1y) << 16);
                total = (64'(frac) * len8 + (64'd1 << 39)) >> 40;
                e.distance = (total > 64'(DIST_MAX)) ? DIST_MAX : total[DIST_W-1:0];
            end
            pending_echoes = {pending_echoes, e};
        endfunction

        function void check_echo(logic [M_TDATA_W-1:0] r);
            echo_t e;
            if (pending_echoes.size() == 0) begin
                $error("unexpected echo %h", r);
                errors++;
                return;
            end
            e = pending_echoes.pop_front();
            if (r[2:0] !== e.sensor) begin
                $error("sensor_echo: expected %0d, got %0d", e.sensor, r[2:0]);
                errors++;
            end
            if (r[3] !== e.hit) begin
                $error("hit: expected %0d, got %0d", e.hit, r[3]);
                errors++;
            end
            if (r[20:4] !== e.distance) begin
                $error("distance: expected %0d, got %0d", e.distance, r[20:4]);
                errors++;
            end
        endfunction
    endclass

    logic                 aclk = 0;
    logic                 aresetn = 0;
    logic                 s_tvalid = 0;
    logic                 s_tready;
    logic [S_TDATA_W-1:0] s_tdata = '0;
    logic                 s_tuser = 0;
    logic                 m_tvalid;
    logic                 m_tready = 0;
    logic [M_TDATA_W-1:0] m_tdata;
    logic                 cfg_valid = 0;
    logic                 cfg_ready;
    logic [6:0]           cfg_data = '0;

    ray_segment_sensor_distance dut (.*);

    ray_scoreboard sb = new();
    int  idle_mode = 0;
    int  holdoff_req = 0;
    longint cycles = 0;

    always begin
        #1 aclk = 1;
        #1 aclk = 0;
    end

    always @(posedge aclk) begin
        cycles++;
        if (cycles > 3000000) begin
            $display("RESULT: ERROR");
            $finish;
        end
    end

    always @(posedge aclk)
        if (aresetn && m_tvalid && m_tready) sb.check_echo(m_tdata);

    // Receiver: random stalls by phase, or one long hold-off on request.
    always @(negedge aclk) begin
        if (holdoff_req > 0) begin
            m_tready = 0;
            repeat (holdoff_req) @(negedge aclk);
            holdoff_req = 0;
        end
        m_tready = !((idle_mode == 2 || idle_mode == 3) &&
                     $urandom_range(99) < ((idle_mode == 2) ? 83 : 37));
    end

    function automatic logic [15:0] rnd_coord(bit near);
        if (near) return 16'($signed($urandom_range(4000)) - 2000);
        return 16'($urandom);
    endfunction

    task automatic send_item(logic act, logic [S_TDATA_W-1:0] d);
        while ((idle_mode == 1 || idle_mode == 3) &&
               $urandom_range(99) < ((idle_mode == 1) ? 83 : 37)) begin
            s_tvalid = 0;
            @(negedge aclk);
        end
        s_tvalid = 1;
        s_tuser = act;
        s_tdata = d;
        forever begin
            @(posedge aclk);
            if (s_tready) break;
        end
        sb.note_item(act, d);
        @(negedge aclk);
        s_tvalid = 0;
    endtask

    task automatic load_vertex(logic [5:0] idx, logic [15:0] x, logic [15:0] y);
        logic [S_TDATA_W-1:0] d;
        d = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[S_TDATA_W-1:105] = '0;
        d[5:0] = idx;
        d[21:6] = x;
        d[37:22] = y;
        send_item(ACT_LOAD, d);
    endtask

    task automatic cast_ray(logic [2:0] sensor, logic [15:0] sx, logic [15:0] sy,
                            logic [15:0] ex, logic [15:0] ey);
        logic [S_TDATA_W-1:0] d;
        d = S_TDATA_W'({$urandom, $urandom, $urandom, $urandom});
        d[S_TDATA_W-1:105] = '0;
        d[40:38] = sensor;
        d[56:41] = sx;
        d[72:57] = sy;
        d[88:73] = ex;
        d[104:89] = ey;
        send_item(ACT_CAST, d);
    endtask

    task automatic drain();
        while (sb.pending_echoes.size() != 0) @(posedge aclk);
        repeat (30) @(posedge aclk);
        @(negedge aclk);
    endtask

    task automatic write_count(logic [6:0] v);
        drain();
        cfg_valid = 1;
        cfg_data = v;
        forever begin
            @(posedge aclk);
            if (cfg_ready) break;
        end
        sb.vertex_count = v;
        @(negedge aclk);
        cfg_valid = 0;
    endtask

    int counts [12] = '{2, 3, 4, 6, 8, 10, 16, 64, 5, 127, 7, 3};

    initial begin
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1;

        // Directed: no segments, a four-vertex path, parallel, touching and extreme rays.
        write_count(0);
        cast_ray(0, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        load_vertex(0, 16'sd0, 16'sd0);
        write_count(1);
        cast_ray(7, -16'sd100, 16'sd0, 16'sd100, 16'sd0);
        load_vertex(1, 16'sd160, 16'sd0);
        load_vertex(2, 16'sd160, 16'sd160);
        load_vertex(3, 16'h8000, 16'h7fff);
        write_count(4);
        cast_ray(1, 16'sd80, -16'sd80, 16'sd80, 16'sd80);
        cast_ray(2, 16'sd0, 16'sd80, 16'sd320, 16'sd80);
        cast_ray(3, 16'sd0, 16'sd40, 16'sd100, 16'sd40);
        cast_ray(4, 16'sd80, 16'sd0, 16'sd80, 16'sd80);
        cast_ray(5, 16'sd80, -16'sd80, 16'sd80, 16'sd0);
        cast_ray(6, 16'h8000, 16'h8000, 16'h7fff, 16'h7fff);
        cast_ray(7, 16'h7fff, 16'h8000, 16'h8000, 16'h7fff);
        cast_ray(0, 16'sd5, 16'sd5, 16'sd5, 16'sd5);
        load_vertex(63, 16'h7fff, 16'h8000);

        for (int i = 0; i < 64; i++) load_vertex(6'(i), rnd_coord(i[0]), rnd_coord(i[0]));

        for (int p = 0; p < 12; p++) begin
            int items;
            bit near;
            write_count(7'(counts[p]));
            idle_mode = p % 4;
            items = (counts[p] > 16) ? 10 : 44;
            near = p[0];
            if (p == 4) holdoff_req = 3000;
            for (int k = 0; k < items; k++) begin
                if ($urandom_range(99) < 30)
                    load_vertex(6'($urandom_range(63)), rnd_coord(near), rnd_coord(near));
                else
                    cast_ray(3'($urandom_range(7)), rnd_coord(near), rnd_coord(near),
                             rnd_coord(near), rnd_coord(near));
                if (p == 6 && k == 20) drain();
            end
        end

        idle_mode = 0;
        while (sb.pending_echoes.size() != 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (sb.errors == 0 && sb.pending_echoes.size() == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end
endmodule

// ----- files.f -----
rtl/rsd_pkg.sv
rtl/rsd_dist.sv
rtl/ray_segment_sensor_distance.sv
sim/testbench.sv
